FILE: hdl/bcpe_pkg.sv
// Shared types and constants of the Bezier curve point evaluator
package bcpe_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic REG_POINT_COUNT   = 1'b0;
    localparam logic REG_SEGMENT_COUNT = 1'b1;

    localparam int COORD_W = 16;
    localparam int FRAC_W  = 17;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        logic             load;
        logic [FRAC_W-1:0] factor;
    } pow_ctl_t;

    // Binomial coefficients C(n,k), indexed by {n, k}
    typedef logic [255:0][16:0] binom_tab_t;

    function automatic binom_tab_t make_binom_tab();
        binom_tab_t tab;
        tab = '0;
        for (int n = 0; n < 16; n++)
        begin
            tab[n*16] = 17'd1;
            for (int k = 1; k <= n; k++)
            begin
                tab[n*16 + k] = 17'(tab[(n-1)*16 + k - 1] + tab[(n-1)*16 + k]);
            end
        end
        return tab;
    endfunction

    localparam binom_tab_t BINOM_TAB = make_binom_tab();

endpackage

FILE: hdl/bcpe_ram.sv
// Generic single-port-write RAM with registered read
module bcpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/bcpe_pow_cell.sv
// One cell of the power chain: holds one rounded power of t or of 1-t
module bcpe_pow_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcpe_pkg::pow_ctl_t     ctl,
    input  logic [16:0]            prev,
    output logic [16:0]            power
);

    logic [16:0] power_reg;
    logic [16:0] power_next;
    logic [33:0] prod;

    assign prod       = prev * ctl.factor;
    assign power_next = ctl.load ? 17'((prod + 34'd32768) >> 16) : power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= '0;
        end
        else
        begin
            power_reg <= power_next;
        end
    end

    assign power = power_reg;

endmodule

FILE: hdl/bezier_curve_point_evaluator_unit.sv
// Top level of the Bezier curve point evaluator
// Usage:
//   Input channel (in_valid/in_stall): cmd 0 stores point_x/y/z at point_index,
//   cmd 1 evaluates sample sample_index and gives one curve point on the
//   output channel (out_valid/out_stall).
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   control_point_count (index 0) and segment_count (index 1); idle only.
// Sequence:
//   A load writes the point store. An evaluate forms t in the divider (one
//   quotient bit a cycle, skipped when sample_index reaches the segment
//   count), then steps the power chain of cells up to power n (n the degree,
//   t and 1-t in lockstep), then forms the weight of each control point and
//   accumulates it in the shared multiply-accumulate, and rounds last.
//   One item is worked at a time; the next is taken once the result sits in
//   the output register, so the receiver may stall while work resumes.
// Reset clears control state and loads count 6 and segments 1000; the point
// store holds no defined value until loaded.
// Stall: the result holds in the output register until its transfer; a later
// result waits in rounding until then.
module bezier_curve_point_evaluator_unit #(
    parameter int MAX_POINTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [2:0]                      point_index,
    input  logic signed [15:0]              point_x,
    input  logic signed [15:0]              point_y,
    input  logic signed [15:0]              point_z,
    input  logic [11:0]                     sample_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              curve_x,
    output logic signed [15:0]              curve_y,
    output logic signed [15:0]              curve_z,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [15:0]                     cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NP = MAX_POINTS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_POW  = 3'd2;
    localparam logic [2:0] ST_WGT  = 3'd3;
    localparam logic [2:0] ST_MAC  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [11:0] seg_reg, seg_next;
    logic [4:0]  step_reg, step_next;
    logic [3:0]  n_reg, n_next;
    logic [3:0]  k_reg, k_next;
    logic [1:0]  ph_reg, ph_next;
    logic [28:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [27:0] num_reg, num_next;
    logic [11:0] div_reg, div_next;
    logic [16:0] t_reg, t_next;
    logic [49:0] w_reg, w_next;
    logic signed [52:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic        ov_reg, ov_next;
    bcpe_pkg::coord_t ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;

    logic               in_acc;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    bcpe_pkg::point_t   ram_wdata, ram_rdata;

    bcpe_pkg::pow_ctl_t tctl, uctl;
    logic [16:0]        tpw [NP];
    logic [16:0]        upw [NP];
    logic [16:0]        tsel, usel;
    logic [3:0]         eff_cnt;
    logic [11:0]        eff_seg;
    logic [28:0]        trial;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign curve_x   = ox_reg;
    assign curve_y   = oy_reg;
    assign curve_z   = oz_reg;

    assign ram_we    = in_acc && (cmd == bcpe_pkg::CMD_LOAD) && (32'(point_index) < NP);
    assign ram_wdata = '{x: point_x, y: point_y, z: point_z};
    assign ram_raddr = AW'(k_reg);

    bcpe_ram #(.WIDTH(48), .DEPTH(NP)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(point_index)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tctl.load   = (state_reg == ST_POW);
    assign tctl.factor = t_reg;
    assign uctl.load   = (state_reg == ST_POW);
    assign uctl.factor = 17'(18'd65536 - 18'(t_reg));

    assign tpw[0] = 17'd65536;
    assign upw[0] = 17'd65536;

    genvar g;
    generate
        for (g = 1; g < NP; g++)
        begin : g_cell
            bcpe_pow_cell u_tc (.clk(clk), .rst_n(rst_n), .ctl(tctl),
                                .prev(tpw[g-1]), .power(tpw[g]));
            bcpe_pow_cell u_uc (.clk(clk), .rst_n(rst_n), .ctl(uctl),
                                .prev(upw[g-1]), .power(upw[g]));
        end
    endgenerate

    assign tsel = tpw[AW'(k_reg)];
    assign usel = upw[AW'(n_reg - k_reg)];

    always_comb
    begin
        if (cnt_reg < 4'd2)
            eff_cnt = 4'd2;
        else if (32'(cnt_reg) > NP)
            eff_cnt = 4'(NP);
        else
            eff_cnt = cnt_reg;
        eff_seg = (seg_reg == 12'd0) ? 12'd1 : seg_reg;
    end

    assign trial = {rem_reg[27:0], num_reg[27]};

    function automatic bcpe_pkg::coord_t sat(input logic signed [52:0] acc);
        logic signed [52:0] r;
        logic signed [20:0] q;
        r = acc + 53'sd2147483648;
        q = r[52:32];
        if (q > 21'sd32767)
            return 16'sh7FFF;
        else if (q < -21'sd32768)
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

    always_comb
    begin
        logic [33:0]        wprod;
        logic signed [52:0] sum_x, sum_y, sum_z;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        seg_next   = seg_reg;
        step_next  = step_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        t_next     = t_reg;
        w_next     = w_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        ov_next    = ov_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        wprod      = tsel * usel;
        sum_x      = '0;
        sum_y      = '0;
        sum_z      = '0;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bcpe_pkg::REG_POINT_COUNT:   cnt_next = cfg_data[3:0];
                bcpe_pkg::REG_SEGMENT_COUNT: seg_next = cfg_data[11:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd == bcpe_pkg::CMD_EVAL)
                begin
                    n_next = eff_cnt - 4'd1;
                    k_next = 4'd0;
                    if (sample_index >= eff_seg)
                    begin
                        t_next     = 17'd65536;
                        step_next  = 5'd0;
                        state_next = ST_POW;
                    end
                    else
                    begin
                        num_next   = {sample_index, 16'd0} + 28'(eff_seg >> 1);
                        div_next   = eff_seg;
                        rem_next   = '0;
                        quo_next   = '0;
                        step_next  = 5'd0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                num_next = {num_reg[26:0], 1'b0};
                if (trial >= 29'(div_reg))
                begin
                    rem_next = trial - 29'(div_reg);
                    quo_next = {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd27)
                begin
                    t_next     = (trial >= 29'(div_reg)) ? {quo_reg[15:0], 1'b1}
                                                          : {quo_reg[15:0], 1'b0};
                    step_next  = 5'd0;
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                step_next = step_reg + 5'd1;
                if (5'(n_reg) == step_reg + 5'd1)
                begin
                    ax_next    = '0;
                    ay_next    = '0;
                    az_next    = '0;
                    ph_next    = 2'd0;
                    state_next = ST_WGT;
                end
            end
            ST_WGT:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    w_next = 50'(wprod);
                end
                else if (ph_reg == 2'd1)
                begin
                    w_next     = 50'(w_reg[33:0] * bcpe_pkg::BINOM_TAB[{n_reg, k_reg}]);
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                sum_x = ax_reg + 53'($signed(ram_rdata.x) * $signed({1'b0, w_reg}));
                sum_y = ay_reg + 53'($signed(ram_rdata.y) * $signed({1'b0, w_reg}));
                sum_z = az_reg + 53'($signed(ram_rdata.z) * $signed({1'b0, w_reg}));
                ax_next = sum_x;
                ay_next = sum_y;
                az_next = sum_z;
                ph_next = 2'd0;
                if (k_reg == n_reg)
                    state_next = ST_RND;
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = ST_WGT;
                end
            end
            ST_RND:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ox_next    = sat(ax_reg);
                    oy_next    = sat(ay_reg);
                    oz_next    = sat(az_reg);
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd6;
            seg_reg   <= 12'd1000;
            step_reg  <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            ph_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seg_reg   <= seg_next;
            step_reg  <= step_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        div_reg <= div_next;
        t_reg   <= t_next;
        w_reg   <= w_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
        oz_reg  <= oz_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_acc)
        else $error("input transfer while busy");
    a_result_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_RND)
        else $error("result without rounding step");
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (k_reg <= n_reg))
        else $error("point index beyond degree");
`endif

endmodule
